### rtl/obrb_pkg.sv
// obrb_pkg: shared types and constants for the overwriting byte ring buffer
// operation and status codes, controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package obrb_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 9;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // operation carried by one input beat
    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR     = 3'd0,
        ACT_WRITE     = 3'd1,
        ACT_READ      = 3'd2,
        ACT_PEEK      = 3'd3,
        ACT_SNAPSHOT  = 3'd4,
        ACT_SNAP_READ = 3'd5
    } action_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_NO_SNAP = 2'd2
    } status_code_t;

    // controller to datapath
    typedef struct packed {
        logic latch_op;    // capture the accepted input beat
        logic commit;      // apply the operation and load the result fields
        logic load_rdata;  // take the memory read data into the result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rd_hit;      // the pending operation returns a byte from memory
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/obrb_ram.sv
// obrb_ram: generic single write port, single read port RAM, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/obrb_ctrl.sv
// obrb_ctrl: controller state machine sequencing one operation at a time
// depends on obrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module obrb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output obrb_pkg::ctrl_cmd_t       cmd,
    input  wire obrb_pkg::dp_stat_t   stat
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_RDATA = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   set_out;

    // result slot can take a new beat when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        set_out    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_op = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    if (stat.rd_hit)
                    begin
                        state_next = S_RDATA;
                    end
                    else
                    begin
                        set_out    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RDATA:
            begin
                cmd.load_rdata = 1'b1;
                set_out        = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat flag
    always_comb
    begin
        if (set_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // result fields are never overwritten while an undelivered beat waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while result slot busy");

    // a memory read always ends in a presented result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |=> out_valid_reg)
        else $error("read data not presented");

    // an accepted input beat goes straight to execution
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    // a waiting result is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before taken");

endmodule

`default_nettype wire

### rtl/obrb_datapath.sv
// obrb_datapath: cursors, counts, snapshot state, byte store and result registers
// depends on obrb_pkg and obrb_ram
`timescale 1ns / 1ps
`default_nettype none

module obrb_datapath #(
    parameter int DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [obrb_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic [obrb_pkg::ACT_W-1:0]    action,
    input  wire logic [obrb_pkg::BYTE_W-1:0]   data_in,
    input  wire logic [obrb_pkg::BYTE_W-1:0]   peek_index,
    input  wire obrb_pkg::ctrl_cmd_t           cmd,
    output obrb_pkg::dp_stat_t                 stat,
    output logic      [obrb_pkg::BYTE_W-1:0]   data_out,
    output logic                               data_valid,
    output logic      [$clog2(DEPTH+1)-1:0]    fill_level,
    output logic                               overwrote,
    output logic      [obrb_pkg::STAT_W-1:0]   status
);

    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = AW + 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int SW      = (LW > obrb_pkg::CFG_W) ? LW : obrb_pkg::CFG_W;
    localparam int PSW     = (LW > obrb_pkg::BYTE_W + 1) ? LW : obrb_pkg::BYTE_W + 1;
    localparam int LEN_RST = (DEPTH < 256) ? DEPTH : 256;

    // latched operation
    obrb_pkg::action_t           act_reg;
    logic [obrb_pkg::BYTE_W-1:0] din_reg;
    logic [obrb_pkg::BYTE_W-1:0] peek_reg;

    // buffer state
    logic [LW-1:0] len_reg;
    logic [AW-1:0] wr_reg,       wr_next;
    logic [AW-1:0] rd_reg,       rd_next;
    logic [LW-1:0] fill_reg,     fill_next;
    logic [AW-1:0] snap_idx_reg, snap_idx_next;
    logic [LW-1:0] snap_cnt_reg, snap_cnt_next;
    logic          snap_ok_reg,  snap_ok_next;

    // result fields
    logic [obrb_pkg::BYTE_W-1:0] dout_reg;
    logic                        dvalid_reg;
    logic [LW-1:0]               rfill_reg;
    logic                        over_reg;
    obrb_pkg::status_code_t      stat_reg;

    // per-operation outcome
    logic                        hit;
    logic                        over;
    obrb_pkg::status_code_t      res_stat;
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [obrb_pkg::BYTE_W-1:0] ram_rdata;
    logic [LW-1:0]               len_cfg;
    logic [SW-1:0]               cfg_ext;
    logic [PSW-1:0]              peek_sum;
    logic [PSW-1:0]              peek_pos;
    logic                        peek_miss;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] i, input logic [LW-1:0] n);
        logic [LW-1:0] inc;
        inc = LW'(i) + LW'(1);
        adv = (inc >= n) ? '0 : AW'(inc);
    endfunction

    // length register clamped to 2..DEPTH when written
    assign cfg_ext = SW'(cfg_wr_data);
    always_comb
    begin
        if (cfg_ext < SW'(2))
        begin
            len_cfg = LW'(2);
        end
        else if (cfg_ext > SW'(DEPTH))
        begin
            len_cfg = LW'(DEPTH);
        end
        else
        begin
            len_cfg = LW'(cfg_ext);
        end
    end

    // peek address: oldest plus offset, wrapped once
    assign peek_sum  = PSW'(rd_reg) + PSW'(peek_reg);
    assign peek_pos  = (peek_sum >= PSW'(len_reg)) ? peek_sum - PSW'(len_reg) : peek_sum;
    assign peek_miss = (PSW'(peek_reg) >= PSW'(fill_reg));

    // operation decode
    always_comb
    begin
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        fill_next     = fill_reg;
        snap_idx_next = snap_idx_reg;
        snap_cnt_next = snap_cnt_reg;
        snap_ok_next  = snap_ok_reg;
        hit           = 1'b0;
        over          = 1'b0;
        res_stat      = obrb_pkg::STAT_OK;
        ram_we        = 1'b0;
        ram_raddr     = rd_reg;
        case (act_reg)
            obrb_pkg::ACT_CLEAR:
            begin
                wr_next   = '0;
                rd_next   = '0;
                fill_next = '0;
            end
            obrb_pkg::ACT_WRITE:
            begin
                ram_we  = 1'b1;
                wr_next = adv(wr_reg, len_reg);
                if (fill_reg >= len_reg)
                begin
                    rd_next   = adv(rd_reg, len_reg);
                    fill_next = len_reg;
                    over      = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + LW'(1);
                end
            end
            obrb_pkg::ACT_READ:
            begin
                if (fill_reg == '0)
                begin
                    res_stat = obrb_pkg::STAT_EMPTY;
                end
                else
                begin
                    hit       = 1'b1;
                    ram_raddr = rd_reg;
                    rd_next   = adv(rd_reg, len_reg);
                    fill_next = fill_reg - LW'(1);
                end
            end
            obrb_pkg::ACT_PEEK:
            begin
                if (peek_miss)
                begin
                    res_stat = obrb_pkg::STAT_EMPTY;
                end
                else
                begin
                    hit       = 1'b1;
                    ram_raddr = AW'(peek_pos);
                end
            end
            obrb_pkg::ACT_SNAPSHOT:
            begin
                snap_idx_next = rd_reg;
                snap_cnt_next = fill_reg;
                snap_ok_next  = 1'b1;
            end
            obrb_pkg::ACT_SNAP_READ:
            begin
                if (!snap_ok_reg)
                begin
                    res_stat = obrb_pkg::STAT_NO_SNAP;
                end
                else if (snap_cnt_reg == '0)
                begin
                    res_stat = obrb_pkg::STAT_EMPTY;
                end
                else
                begin
                    hit           = 1'b1;
                    ram_raddr     = snap_idx_reg;
                    snap_idx_next = adv(snap_idx_reg, len_reg);
                    snap_cnt_next = snap_cnt_reg - LW'(1);
                end
            end
            default:
            begin
                res_stat = obrb_pkg::STAT_OK;
            end
        endcase
    end

    assign stat.rd_hit = hit;

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_op)
        begin
            act_reg  <= obrb_pkg::action_t'(action);
            din_reg  <= data_in;
            peek_reg <= peek_index;
        end
    end

    // buffer state: a length write clears everything, including the snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LW'(LEN_RST);
            wr_reg       <= '0;
            rd_reg       <= '0;
            fill_reg     <= '0;
            snap_idx_reg <= '0;
            snap_cnt_reg <= '0;
            snap_ok_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            len_reg      <= len_cfg;
            wr_reg       <= '0;
            rd_reg       <= '0;
            fill_reg     <= '0;
            snap_idx_reg <= '0;
            snap_cnt_reg <= '0;
            snap_ok_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            fill_reg     <= fill_next;
            snap_idx_reg <= snap_idx_next;
            snap_cnt_reg <= snap_cnt_next;
            snap_ok_reg  <= snap_ok_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            dout_reg   <= '0;
            dvalid_reg <= hit;
            rfill_reg  <= fill_next;
            over_reg   <= over;
            stat_reg   <= res_stat;
        end
        else if (cmd.load_rdata)
        begin
            dout_reg <= ram_rdata;
        end
    end

    // byte store
    obrb_ram #(
        .WIDTH (obrb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit && ram_we),
        .waddr (wr_reg),
        .wdata (din_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign data_out   = dout_reg;
    assign data_valid = dvalid_reg;
    assign fill_level = CW'(rfill_reg);
    assign overwrote  = over_reg;
    assign status     = stat_reg;

endmodule

`default_nettype wire

### rtl/overwriting_byte_ring_buffer.sv
// Overwriting byte ring buffer: one operation per input beat, one result beat
// for each (clear, write, read, peek, snapshot, snapshot read). An operation
// is accepted, then applies and loads its result; one that returns a byte
// takes a further step to load it, since the byte store has a registered read
// port, and the result beat is registered from that load. The input is taken
// again as soon as the result is loaded, so the block takes no new operation
// before it is through with the last one. A waiting result does not block
// acceptance of the next beat, but that beat is held until the result is
// taken. Writing the length register clamps it to 2..DEPTH, empties the buffer
// and drops the snapshot; write it only while no operation is in flight. The
// store needs no clearing pass after reset.
// depends on obrb_pkg, obrb_ctrl, obrb_datapath
`timescale 1ns / 1ps
`default_nettype none

module overwriting_byte_ring_buffer #(
    parameter int DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [obrb_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [obrb_pkg::ACT_W-1:0]    action,
    input  wire logic [obrb_pkg::BYTE_W-1:0]   data_in,
    input  wire logic [obrb_pkg::BYTE_W-1:0]   peek_index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [obrb_pkg::BYTE_W-1:0]   data_out,
    output logic                               data_valid,
    output logic      [$clog2(DEPTH+1)-1:0]    fill_level,
    output logic                               overwrote,
    output logic      [obrb_pkg::STAT_W-1:0]   status
);

    obrb_pkg::ctrl_cmd_t cmd;
    obrb_pkg::dp_stat_t  stat;

    // sequencing
    obrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // cursors, store and results
    obrb_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .action      (action),
        .data_in     (data_in),
        .peek_index  (peek_index),
        .cmd         (cmd),
        .stat        (stat),
        .data_out    (data_out),
        .data_valid  (data_valid),
        .fill_level  (fill_level),
        .overwrote   (overwrote),
        .status      (status)
    );

endmodule

`default_nettype wire

### tb/sv/overwriting_byte_ring_buffer_test.sv
// overwriting_byte_ring_buffer_test: self-checking testbench for the byte ring buffer
// mirrors the ring state to predict every result beat, drives bursty traffic and stalls
// depends on obrb_pkg and overwriting_byte_ring_buffer
`timescale 1ns / 1ps

module overwriting_byte_ring_buffer_test;

    localparam int RING_DEPTH  = 256;
    localparam int LEVEL_W     = $clog2(RING_DEPTH + 1);
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;

    // action codes the block treats as no-ops
    localparam logic [obrb_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [obrb_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd7;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PATTERN
    } ready_mode_t;

    typedef struct packed {
        logic [obrb_pkg::BYTE_W-1:0] data_out;
        logic                        data_valid;
        logic [LEVEL_W-1:0]          fill_level;
        logic                        overwrote;
        obrb_pkg::status_code_t      status;
    } ring_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [obrb_pkg::CFG_W-1:0]    cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [obrb_pkg::ACT_W-1:0]    action = '0;
    logic [obrb_pkg::BYTE_W-1:0]   data_in = '0;
    logic [obrb_pkg::BYTE_W-1:0]   peek_index = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [obrb_pkg::BYTE_W-1:0]   data_out;
    logic                          data_valid;
    logic [LEVEL_W-1:0]            fill_level;
    logic                          overwrote;
    logic [obrb_pkg::STAT_W-1:0]   status;

    // mirror of the ring state
    logic [obrb_pkg::BYTE_W-1:0]   mirror_store [RING_DEPTH];
    int unsigned          wr_slot = 0;
    int unsigned          rd_slot = 0;
    int unsigned          held_bytes = 0;
    int unsigned          snap_slot = 0;
    int unsigned          snap_left = 0;
    bit                   snap_taken = 1'b0;
    int unsigned          length_reg = 256;

    ring_result_t         outcomes_due[$];
    int                   mismatch_count = 0;
    int                   burst_left = 0;
    bit                   sender_steady = 1'b0;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;

    overwriting_byte_ring_buffer #(
        .DEPTH(RING_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .data_in    (data_in),
        .peek_index (peek_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .data_valid (data_valid),
        .fill_level (fill_level),
        .overwrote  (overwrote),
        .status     (status)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cursor step with wrap at the active length
    function automatic int unsigned next_slot(input int unsigned slot, input int unsigned len);
        return (slot + 1 >= len) ? 0 : slot + 1;
    endfunction

    // apply one operation to the mirror and return the beat it should produce
    function automatic ring_result_t ring_op_outcome(
        input logic [obrb_pkg::ACT_W-1:0]  act,
        input logic [obrb_pkg::BYTE_W-1:0] din,
        input logic [obrb_pkg::BYTE_W-1:0] offset);
        ring_result_t res;
        int unsigned  len;
        int unsigned  slot;
        res = '0;
        res.status = obrb_pkg::STAT_OK;
        len = (length_reg < 2) ? 2 : (length_reg > RING_DEPTH) ? RING_DEPTH : length_reg;
        case (act)
            obrb_pkg::ACT_CLEAR:
            begin
                wr_slot = 0;
                rd_slot = 0;
                held_bytes = 0;
            end
            obrb_pkg::ACT_WRITE:
            begin
                mirror_store[wr_slot] = din;
                // full: drop the oldest byte
                if (held_bytes >= len)
                begin
                    rd_slot = next_slot(rd_slot, len);
                    held_bytes = len - 1;
                    res.overwrote = 1'b1;
                end
                wr_slot = next_slot(wr_slot, len);
                held_bytes++;
            end
            obrb_pkg::ACT_READ:
            begin
                if (held_bytes == 0)
                    res.status = obrb_pkg::STAT_EMPTY;
                else
                begin
                    res.data_out = mirror_store[rd_slot];
                    res.data_valid = 1'b1;
                    rd_slot = next_slot(rd_slot, len);
                    held_bytes--;
                end
            end
            obrb_pkg::ACT_PEEK:
            begin
                if (offset >= held_bytes)
                    res.status = obrb_pkg::STAT_EMPTY;
                else
                begin
                    slot = rd_slot + offset;
                    if (slot >= len)
                        slot -= len;
                    res.data_out = mirror_store[slot];
                    res.data_valid = 1'b1;
                end
            end
            obrb_pkg::ACT_SNAPSHOT:
            begin
                snap_slot = rd_slot;
                snap_left = held_bytes;
                snap_taken = 1'b1;
            end
            obrb_pkg::ACT_SNAP_READ:
            begin
                if (!snap_taken)
                    res.status = obrb_pkg::STAT_NO_SNAP;
                else if (snap_left == 0)
                    res.status = obrb_pkg::STAT_EMPTY;
                else
                begin
                    // snapshot walks live storage
                    res.data_out = mirror_store[snap_slot];
                    res.data_valid = 1'b1;
                    snap_slot = next_slot(snap_slot, len);
                    snap_left--;
                end
            end
            default:
            begin
            end
        endcase
        res.fill_level = held_bytes[LEVEL_W-1:0];
        return res;
    endfunction

    // offer one beat, with bursts and random gaps, and predict once accepted
    task automatic send_op(input logic [obrb_pkg::ACT_W-1:0] act,
                           input logic [obrb_pkg::BYTE_W-1:0] din,
                           input logic [obrb_pkg::BYTE_W-1:0] offset);
        int gap;
        if (burst_left == 0)
        begin
            gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        data_in <= din;
        peek_index <= offset;
        do
            @(posedge clk);
        while (!in_ready);
        outcomes_due.push_back(ring_op_outcome(act, din, offset));
    endtask

    // weighted random operation, peek offsets mostly near the fill level
    task automatic send_random_op();
        int unsigned                 pick;
        logic [obrb_pkg::ACT_W-1:0]  act;
        logic [obrb_pkg::BYTE_W-1:0] offset;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            act = obrb_pkg::ACT_WRITE;
        else if (pick < 52)
            act = obrb_pkg::ACT_READ;
        else if (pick < 66)
            act = obrb_pkg::ACT_PEEK;
        else if (pick < 73)
            act = obrb_pkg::ACT_SNAPSHOT;
        else if (pick < 89)
            act = obrb_pkg::ACT_SNAP_READ;
        else if (pick < 94)
            act = obrb_pkg::ACT_CLEAR;
        else if (pick < 97)
            act = ACT_SPARE_A;
        else
            act = ACT_SPARE_B;
        offset = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, held_bytes));
        send_op(act, 8'($urandom), offset);
    endtask

    // length register write, only once the block has drained
    task automatic write_length(input logic [obrb_pkg::CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        length_reg = value;
        wr_slot = 0;
        rd_slot = 0;
        held_bytes = 0;
        snap_slot = 0;
        snap_left = 0;
        snap_taken = 1'b0;
        burst_left = 0;
    endtask

    // empty reads, missing snapshot, exhausted snapshot and the spare actions
    task automatic test_empty_and_spare_ops();
        send_op(obrb_pkg::ACT_READ, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
        send_op(ACT_SPARE_A, 8'hFF, 8'hFF);
        send_op(ACT_SPARE_B, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_SNAPSHOT, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
    endtask

    // shortest ring: overwrite, peek limits, snapshot surviving a clear
    task automatic test_overwrite_and_clear();
        write_length(9'd0);
        send_op(obrb_pkg::ACT_WRITE, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_WRITE, 8'hFF, 8'h00);
        send_op(obrb_pkg::ACT_WRITE, 8'hA5, 8'h00);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd0);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd1);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd2);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd255);
        send_op(obrb_pkg::ACT_SNAPSHOT, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_CLEAR, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_WRITE, 8'h5A, 8'h00);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_READ, 8'h00, 8'h00);
        send_op(obrb_pkg::ACT_READ, 8'h00, 8'h00);
        write_length(9'd1);
        send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
    endtask

    // oversized length saturates to the full store: fill past it and drain
    task automatic test_full_length();
        write_length(9'd511);
        for (int i = 0; i < 260; i++)
            send_op(obrb_pkg::ACT_WRITE, 8'($urandom), 8'($urandom));
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd255);
        send_op(obrb_pkg::ACT_PEEK, 8'h00, 8'd0);
        send_op(obrb_pkg::ACT_SNAPSHOT, 8'h00, 8'h00);
        for (int i = 0; i < 257; i++)
            send_op(obrb_pkg::ACT_READ, 8'h00, 8'h00);
        for (int i = 0; i < 3; i++)
            send_op(obrb_pkg::ACT_SNAP_READ, 8'h00, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_backpressure();
        write_length(9'd9);
        sender_steady = 1'b1;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
            send_random_op();
        sender_steady = 1'b0;
    endtask

    // random traffic over a spread of lengths, extremes included
    task automatic test_random_traffic();
        logic [obrb_pkg::CFG_W-1:0] len_value;
        for (int ph = 0; ph < 11; ph++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len_value = 9'($urandom_range(2, 12));
                5:             len_value = 9'($urandom_range(13, 64));
                6:             len_value = 9'd256;
                7:             len_value = 9'd2;
                8:             len_value = 9'($urandom_range(0, 1));
                default:       len_value = 9'($urandom_range(257, 511));
            endcase
            write_length(len_value);
            for (int i = 0; i < 125; i++)
                send_random_op();
        end
    endtask

    // receiver stall patterns, with a long hold when requested
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int unsigned stall_tick = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                RDY_ALWAYS:  out_ready <= 1'b1;
                RDY_HALF:    out_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                default:     out_ready <= ((stall_tick % 7) < 4);
            endcase
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (data_out !== want.data_out)
                begin
                    $error("data_out: expected %0d, got %0d", want.data_out, data_out);
                    mismatch_count++;
                end
                if (data_valid !== want.data_valid)
                begin
                    $error("data_valid: expected %0d, got %0d", want.data_valid, data_valid);
                    mismatch_count++;
                end
                if (fill_level !== want.fill_level)
                begin
                    $error("fill_level: expected %0d, got %0d", want.fill_level, fill_level);
                    mismatch_count++;
                end
                if (overwrote !== want.overwrote)
                begin
                    $error("overwrote: expected %0d, got %0d", want.overwrote, overwrote);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_and_spare_ops();
        test_overwrite_and_clear();
        test_full_length();
        test_output_backpressure();
        test_random_traffic();
        // drain and let the pipeline settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### overwriting_byte_ring_buffer.f
rtl/obrb_pkg.sv
rtl/obrb_ram.sv
rtl/obrb_ctrl.sv
rtl/obrb_datapath.sv
rtl/overwriting_byte_ring_buffer.sv
tb/sv/overwriting_byte_ring_buffer_test.sv
